@@ design/jet_pkg.sv @@
// Shared constants and types for the Julia escape-time pixel evaluator.
package jet_pkg;

    localparam int MAX_ITER_DEF  = 256;
    localparam int FRAC_BITS_DEF = 26;

    localparam int REG_W     = 30;
    localparam int REG_FRAC  = 26;
    localparam int POS_W     = 16;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Half of the normalized range in Q2.14: (pos + 1) / 2 becomes (pos + POS_HALF) / 2^15.
    localparam int POS_HALF  = 16384;
    localparam int POS_SHIFT = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_RE = 2'd0,
        CFG_SCALE_IM = 2'd1,
        CFG_CONST_RE = 2'd2,
        CFG_CONST_IM = 2'd3
    } t_cfg_idx;

    localparam logic signed [REG_W-1:0] RST_SCALE_RE = 30'sd214748365;
    localparam logic signed [REG_W-1:0] RST_SCALE_IM = 30'sd161061274;
    localparam logic signed [REG_W-1:0] RST_CONST_RE = -30'sd50331648;
    localparam logic signed [REG_W-1:0] RST_CONST_IM = 30'sd0;

    typedef struct packed {
        logic [COUNT_W-1:0] escape_count;
        logic               never_escaped;
    } t_result;

endpackage

@@ design/jet_front.sv @@
// Front end: accepts a pixel item and maps it to the starting point of the iteration.
module jet_front
    import jet_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int W         = FRAC_BITS + 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [POS_W-1:0]       i_pos_x,
    input  logic [POS_W-1:0]       i_pos_y,
    input  logic signed [W-1:0]    i_span_re,
    input  logic signed [W-1:0]    i_span_im,
    output logic                   o_busy,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*W-1:0]         o_point
);

    localparam int PW = POS_W + 1;
    localparam int MW = W + PW;

    localparam longint ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [W-1:0] OFF_RE = W'((8 * ONE + 2) / 5);
    localparam logic signed [W-1:0] OFF_IM = W'((6 * ONE + 2) / 5);

    localparam logic signed [W-1:0]   MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W-1:0] MAX2 = (2*W)'(MAXV);
    localparam logic signed [2*W-1:0] MIN2 = (2*W)'(MINV);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_MAP, S_PUSH} t_state;

    t_state r_state;
    logic signed [PW-1:0] r_px, r_py;
    logic signed [MW-1:0] r_prx, r_pry;
    logic signed [W-1:0]  r_zr, r_zi;

    function automatic logic signed [W-1:0] sat_fix(input logic signed [2*W-1:0] v);
        logic signed [W-1:0] r;
        if (v > MAX2)      r = MAXV;
        else if (v < MIN2) r = MINV;
        else               r = v[W-1:0];
        return r;
    endfunction

    // Floor the scaled product back to the working format, then remove the view offset.
    function automatic logic signed [W-1:0] map_coord(input logic signed [MW-1:0] prod,
                                                       input logic signed [W-1:0]  off);
        logic signed [W-1:0] t;
        t = sat_fix((2*W)'(prod >>> POS_SHIFT));
        return sat_fix((2*W)'(t) - (2*W)'(off));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_px    <= PW'($signed(i_pos_x)) + PW'(POS_HALF);
                        r_py    <= PW'($signed(i_pos_y)) + PW'(POS_HALF);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prx   <= i_span_re * r_px;
                    r_pry   <= i_span_im * r_py;
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    r_zr    <= map_coord(r_prx, OFF_RE);
                    r_zi    <= map_coord(r_pry, OFF_IM);
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_PUSH);
    assign o_point = {r_zr, r_zi};

endmodule

@@ design/jet_queue.sv @@
// Two-entry queue of starting points between the front end and the iteration engine.
module jet_queue
    import jet_pkg::*;
#(
    parameter int DW = 2 * (FRAC_BITS_DEF + 6)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ design/jet_back.sv @@
// Iteration engine: runs z = z*z + c on one point and reports its escape count.
module jet_back
    import jet_pkg::*;
#(
    parameter int MAX_ITER  = MAX_ITER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int W         = FRAC_BITS + 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2*W-1:0]      i_point,
    input  logic signed [W-1:0] i_const_re,
    input  logic signed [W-1:0] i_const_im,
    output logic                o_valid,
    output t_result             o_result
);

    localparam int H   = W / 2;
    localparam int HW  = W - H;
    localparam int LW  = W + H + 1;
    localparam int UW  = W + HW;
    localparam int CW  = $clog2(MAX_ITER + 1);

    localparam logic signed [W-1:0]   MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W-1:0] MAX2 = (2*W)'(MAXV);
    localparam logic signed [2*W-1:0] MIN2 = (2*W)'(MINV);
    localparam logic signed [W-1:0]   FOUR = W'(64'sd4 <<< FRAC_BITS);
    localparam logic [CW-1:0]         KMAX = CW'(MAX_ITER);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_RND, S_TST} t_state;

    t_state r_state;
    logic signed [W-1:0]  r_zr, r_zi;
    logic signed [W-1:0]  r_rr, r_ii, r_ri;
    logic signed [LW-1:0] r_lo_rr, r_lo_ii, r_lo_ri;
    logic signed [UW-1:0] r_hi_rr, r_hi_ii, r_hi_ri;
    logic [CW-1:0]        r_k;
    logic                 r_out_valid;
    t_result              r_result;

    logic signed [W-1:0]  mag, s_diff, s_dbl, zr_n, zi_n;
    logic                 escaped, last;
    logic [CW-1:0]        k_inc;

    function automatic logic signed [W-1:0] sat_fix(input logic signed [2*W-1:0] v);
        logic signed [W-1:0] r;
        if (v > MAX2)      r = MAXV;
        else if (v < MIN2) r = MINV;
        else               r = v[W-1:0];
        return r;
    endfunction

    // Lower partial product: the low half of b is taken as unsigned.
    function automatic logic signed [LW-1:0] mul_lo(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [H:0] bl;
        bl = $signed({1'b0, b[H-1:0]});
        return a * bl;
    endfunction

    // Upper partial product: the high half of b carries the sign.
    function automatic logic signed [UW-1:0] mul_hi(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [HW-1:0] bh;
        bh = $signed(b[W-1:H]);
        return a * bh;
    endfunction

    // Join the partial products, floor to the working format and saturate.
    function automatic logic signed [W-1:0] mul_join(input logic signed [LW-1:0] lo,
                                                      input logic signed [UW-1:0] hi);
        logic signed [2*W-1:0] full;
        full = (2*W)'(lo) + ((2*W)'(hi) <<< H);
        return sat_fix(full >>> FRAC_BITS);
    endfunction

    always_comb begin
        mag     = sat_fix((2*W)'(r_rr) + (2*W)'(r_ii));
        escaped = (mag > FOUR);
        s_diff  = sat_fix((2*W)'(r_rr) - (2*W)'(r_ii));
        s_dbl   = sat_fix((2*W)'(r_ri) + (2*W)'(r_ri));
        zr_n    = sat_fix((2*W)'(s_diff) + (2*W)'(i_const_re));
        zi_n    = sat_fix((2*W)'(s_dbl) + (2*W)'(i_const_im));
        k_inc   = r_k + 1'b1;
        last    = (k_inc == KMAX);
    end

    function automatic t_result make_result(input logic [CW-1:0] k, input logic never);
        logic [CW+COUNT_W-1:0] kx;
        t_result r;
        kx = (CW + COUNT_W)'(k);
        r.escape_count  = kx[COUNT_W-1:0];
        r.never_escaped = never;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_zr    <= i_point[2*W-1:W];
                        r_zi    <= i_point[W-1:0];
                        r_k     <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_lo_rr <= mul_lo(r_zr, r_zr);
                    r_hi_rr <= mul_hi(r_zr, r_zr);
                    r_lo_ii <= mul_lo(r_zi, r_zi);
                    r_hi_ii <= mul_hi(r_zi, r_zi);
                    r_lo_ri <= mul_lo(r_zr, r_zi);
                    r_hi_ri <= mul_hi(r_zr, r_zi);
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_rr    <= mul_join(r_lo_rr, r_hi_rr);
                    r_ii    <= mul_join(r_lo_ii, r_hi_ii);
                    r_ri    <= mul_join(r_lo_ri, r_hi_ri);
                    r_state <= S_TST;
                end
                S_TST: begin
                    if (escaped) begin
                        r_result    <= make_result(r_k, 1'b0);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (last) begin
                        r_result    <= make_result(k_inc, 1'b1);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_zr    <= zr_n;
                        r_zi    <= zi_n;
                        r_k     <= k_inc;
                        r_state <= S_MUL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

@@ design/julia_escape_time.sv @@
// Top level of the Julia escape-time pixel evaluator.
//
// An item is one pixel position (i_pos_x, i_pos_y) in Q2.14. It is taken at a
// rising edge where start is high and busy is low. The front end maps the
// position into the view (multiply, then map) and parks the starting point in a
// two-entry queue, so busy drops again as soon as the point has entered that
// queue, even while the iteration engine is still working on older items.
// The engine iterates z = z*z + c with one set of partial-product multipliers;
// each iteration steps through partial products, floor and saturate, and
// escape test and update. An item runs at most MAX_ITER escape tests: the
// escape count plus one, or MAX_ITER when the point never escapes. The engine
// takes the next item from the queue only once it is back in idle.
// Each result is shown on o_escape_count and o_never_escaped for exactly one
// cycle with o_valid high; the receiver cannot stall, so results are never held.
// Configuration (view spans and Julia constant, Q4.26) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while the block
// is idle, which the block itself does not enforce. Synchronous active-low
// reset empties the queue, idles both halves and loads the default configuration registers.
module julia_escape_time
    import jet_pkg::*;
#(
    parameter int MAX_ITER  = MAX_ITER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [COUNT_W-1:0]   o_escape_count,
    output logic                 o_never_escaped
);

    localparam int W   = FRAC_BITS + 6;
    localparam int SHL = (FRAC_BITS >= REG_FRAC) ? FRAC_BITS - REG_FRAC : 0;
    localparam int SHR = (FRAC_BITS <  REG_FRAC) ? REG_FRAC - FRAC_BITS : 0;

    logic signed [REG_W-1:0] r_scale_re, r_scale_im, r_const_re, r_const_im;
    logic signed [W-1:0]     span_re, span_im, c_re, c_im;

    logic                    f_valid, q_ready, q_valid, b_ready;
    logic [2*W-1:0]          f_point, q_point;
    t_result                 result;

    // Register values carry 26 fraction bits; a narrower format floors them.
    function automatic logic signed [W-1:0] reg_to_fix(input logic signed [REG_W-1:0] v);
        logic signed [63:0] e;
        e = (64'(v) <<< SHL) >>> SHR;
        return W'(e);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_re <= RST_SCALE_RE;
            r_scale_im <= RST_SCALE_IM;
            r_const_re <= RST_CONST_RE;
            r_const_im <= RST_CONST_IM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE_RE: r_scale_re <= i_cfg_data;
                CFG_SCALE_IM: r_scale_im <= i_cfg_data;
                CFG_CONST_RE: r_const_re <= i_cfg_data;
                CFG_CONST_IM: r_const_im <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign span_re = reg_to_fix(r_scale_re);
    assign span_im = reg_to_fix(r_scale_im);
    assign c_re    = reg_to_fix(r_const_re);
    assign c_im    = reg_to_fix(r_const_im);

    jet_front #(
        .FRAC_BITS (FRAC_BITS),
        .W         (W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_span_re (span_re),
        .i_span_im (span_im),
        .o_busy    (busy),
        .o_valid   (f_valid),
        .i_ready   (q_ready),
        .o_point   (f_point)
    );

    jet_queue #(
        .DW (2 * W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (q_ready),
        .i_data  (f_point),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_data  (q_point)
    );

    jet_back #(
        .MAX_ITER  (MAX_ITER),
        .FRAC_BITS (FRAC_BITS),
        .W         (W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_ready    (b_ready),
        .i_point    (q_point),
        .i_const_re (c_re),
        .i_const_im (c_im),
        .o_valid    (o_valid),
        .o_result   (result)
    );

    assign o_escape_count  = result.escape_count;
    assign o_never_escaped = result.never_escaped;

endmodule
